>>> sv/lft_pkg.sv
// Package: shared types, byte kind codes and defaults for the LIN frame transmitter.
package lft_pkg;

    localparam int BREAK_BYTES_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] BREAK_BYTE = 8'h00;

    typedef enum logic [2:0] {
        KIND_BREAK = 3'd0,
        KIND_SYNC  = 3'd1,
        KIND_PID   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_CSUM  = 3'd4
    } byte_kind_t;

    typedef struct packed {
        logic       start_frame;
        logic       end_frame;
        logic [5:0] frame_id;
        logic [7:0] data_byte;
    } lft_in_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic [2:0] byte_kind;
        logic       run_last;
    } lft_out_t;

    // One queued job: a header run or a single data byte, with optional checksum
    typedef struct packed {
        logic       is_header;
        logic [7:0] body_byte;
        logic [7:0] csum_byte;
        logic       has_csum;
    } lft_job_t;

endpackage

>>> sv/lft_top.sv
// Top level: LIN frame transmitter, front end, job queue and byte sequencer.
//
//  channel  | valid        | ready        | payload            | moves
//  ---------+--------------+--------------+--------------------+-------------------------
//  input    | item_valid   | item_ready   | item   (lft_in_t)  | one frame item per transfer
//  output   | result_valid | result_ready | result (lft_out_t) | one line byte per transfer
//
// Bytes: the sequencer emits one byte per cycle while a job waits and the output is not
//   stalled. A data item makes one byte (two with its checksum); a start item makes
//   BREAK_BYTES+2 bytes (BREAK_BYTES+3 with checksum), through a single output byte register.
// Reset: rst_n clears frame state, queue pointers and the output valid at once.
// Stalls: the job queue lets the front end keep taking items while the output stalls;
//   item_ready drops only when the queue is full. Data outside a frame is absorbed.
module lin_frame_transmitter_top
    import lft_pkg::*;
#(
    parameter int BREAK_BYTES = BREAK_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  lft_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output lft_out_t result
);

    // Front end to queue
    logic     push;
    lft_job_t push_job;
    logic     q_full;

    // Queue to sequencer
    logic     q_empty;
    logic     pop;
    lft_job_t head_job;

    lft_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (q_full),
        .job_push   (push),
        .job        (push_job)
    );

    lft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Sequencer: one byte per cycle into the output register while the output is not stalled
    lft_back #(
        .BREAK_BYTES (BREAK_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (~q_empty),
        .job          (head_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> sv/lft_front.sv
// Front end: takes input transfers, tracks the open frame and checksum, issues jobs.
module lft_front
    import lft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  lft_in_t  item,
    input  logic     queue_full,
    output logic     job_push,
    output lft_job_t job
);

    logic       open_reg, open_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] pid;
    logic [8:0] raw_sum;
    logic [7:0] folded;
    logic       accept;

    // Parity in bits 7 and 6
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    assign item_ready = ~queue_full;
    assign accept     = item_valid & item_ready;
    assign pid        = protect_id(item.frame_id);

    // End-around carry: s - 255 == s[7:0] + 1 when s > 255
    assign raw_sum = {1'b0, sum_reg} + {1'b0, item.data_byte};
    assign folded  = raw_sum[8] ? (raw_sum[7:0] + 8'd1) : raw_sum[7:0];

    always_comb
    begin
        open_next     = open_reg;
        sum_next      = sum_reg;
        job_push      = 1'b0;
        job.is_header = item.start_frame;
        job.has_csum  = item.end_frame;
        job.body_byte = item.start_frame ? pid : item.data_byte;
        job.csum_byte = item.start_frame ? ~pid : ~folded;
        if (accept)
        begin
            if (item.start_frame)
            begin
                job_push  = 1'b1;
                open_next = ~item.end_frame;
                sum_next  = item.end_frame ? 8'd0 : pid;
            end
            else if (open_reg)
            begin
                job_push  = 1'b1;
                open_next = ~item.end_frame;
                sum_next  = item.end_frame ? 8'd0 : folded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            sum_reg  <= 8'd0;
        end
        else
        begin
            open_reg <= open_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

>>> sv/lft_queue.sv
// Job queue: small register FIFO between the front end and the byte sequencer.
module lft_queue
    import lft_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lft_job_t push_job,
    input  logic     pop,
    output lft_job_t head_job,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lft_job_t             slot_reg [DEPTH];
    logic     [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic     [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic     [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> sv/lft_back.sv
// Back end: walks each job byte by byte into the output register.
module lft_back
    import lft_pkg::*;
#(
    parameter int BREAK_BYTES = BREAK_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  lft_job_t job,
    output logic     job_pop,
    output logic     result_valid,
    input  logic     result_ready,
    output lft_out_t result
);

    localparam int SW = $clog2(BREAK_BYTES + 3);

    logic [SW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    lft_out_t      out_reg, out_next;
    logic [SW-1:0] last_step;
    logic          load;
    logic          at_last;

    always_comb
    begin
        if (job.is_header)
            last_step = job.has_csum ? SW'(BREAK_BYTES + 2) : SW'(BREAK_BYTES + 1);
        else
            last_step = job.has_csum ? SW'(1) : SW'(0);
    end

    assign load    = job_valid && (!out_valid_reg || result_ready);
    assign at_last = (step_reg == last_step);
    assign job_pop = load && at_last;

    always_comb
    begin
        out_next.run_last = at_last;
        if (job.is_header)
        begin
            if (step_reg < SW'(BREAK_BYTES))
            begin
                out_next.line_byte = BREAK_BYTE;
                out_next.byte_kind = KIND_BREAK;
            end
            else if (step_reg == SW'(BREAK_BYTES))
            begin
                out_next.line_byte = SYNC_BYTE;
                out_next.byte_kind = KIND_SYNC;
            end
            else if (step_reg == SW'(BREAK_BYTES + 1))
            begin
                out_next.line_byte = job.body_byte;
                out_next.byte_kind = KIND_PID;
            end
            else
            begin
                out_next.line_byte = job.csum_byte;
                out_next.byte_kind = KIND_CSUM;
            end
        end
        else if (step_reg == '0)
        begin
            out_next.line_byte = job.body_byte;
            out_next.byte_kind = KIND_DATA;
        end
        else
        begin
            out_next.line_byte = job.csum_byte;
            out_next.byte_kind = KIND_CSUM;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = at_last ? '0 : step_reg + SW'(1);
        end
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SW'(BREAK_BYTES + 2))
        else $error("sequencer step out of range");
    a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> job_valid)
        else $error("job left queue before its last byte");
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> result_valid && result.run_last)
        else $error("job retired without a last-marked byte");

endmodule

>>> tb/sv/lin_frame_transmitter_top_tb.sv
// Testbench: LIN frame transmitter, directed and random frame streams checked byte by byte.
`timescale 1ns / 100ps

module lin_frame_transmitter_top_tb;
    import lft_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          BREAK_COUNT  = BREAK_BYTES_DEF;
    localparam int          ITEM_TARGET  = 470;
    // Quiet cycles after the last expected byte: a full header run plus the queue.
    localparam int          SETTLE_CYCLES = 32;
    localparam int unsigned LIMIT_NS     = 10_000_000;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    lft_in_t  item;
    logic     result_valid;
    logic     result_ready;
    lft_out_t result;

    // Bytes still owed by the DUT, oldest first.
    lft_out_t pending_bytes[$];

    // Shadow of the frame state: open flag and folded checksum accumulator.
    logic       frm_open;
    logic [7:0] csum_acc;

    // Idle control for the sender task and the receiver process.
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_req;

    // Bookkeeping.
    int err_count;
    int items_sent;
    int items_effective;
    int bytes_checked;
    int frames_closed;
    int frames_dropped;
    int holds_done;
    int input_stall_cycles;

    lin_frame_transmitter_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the DUT hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Identifier in bits 5..0, parity P0 in bit 6, inverted P1 in bit 7.
    function automatic logic [7:0] protected_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // 8-bit add with end-around carry.
    function automatic logic [7:0] carry_fold_add(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic lft_out_t line_byte_of(input logic [7:0] b, input byte_kind_t kind);
        lft_out_t o;
        o.line_byte = b;
        o.byte_kind = kind;
        o.run_last  = 1'b0;
        return o;
    endfunction

    // Queue the bytes one accepted item must produce and advance the shadow state.
    task automatic predict_line_bytes(input lft_in_t it);
        lft_out_t   run[$];
        logic [7:0] pid;
        if (it.start_frame)
        begin
            if (frm_open)
                frames_dropped++;
            pid = protected_id(it.frame_id);
            for (int k = 0; k < BREAK_COUNT; k++)
                run.push_back(line_byte_of(BREAK_BYTE, KIND_BREAK));
            run.push_back(line_byte_of(SYNC_BYTE, KIND_SYNC));
            run.push_back(line_byte_of(pid, KIND_PID));
            csum_acc = pid;
            frm_open = 1'b1;
        end
        else if (frm_open)
        begin
            run.push_back(line_byte_of(it.data_byte, KIND_DATA));
            csum_acc = carry_fold_add(csum_acc, it.data_byte);
        end
        else
        begin
            // Data outside a frame is swallowed; end flag ignored.
            return;
        end
        if (it.end_frame)
        begin
            run.push_back(line_byte_of(~csum_acc, KIND_CSUM));
            frm_open = 1'b0;
            csum_acc = 8'h00;
            frames_closed++;
        end
        run[run.size() - 1].run_last = 1'b1;
        foreach (run[k])
            pending_bytes.push_back(run[k]);
        items_effective++;
    endtask

    //------------------------------------------------------------------
    // Mismatch reporting and result check
    //------------------------------------------------------------------

    task automatic log_mismatch(input string what, input int unsigned got, input int unsigned want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_line_byte(input lft_out_t got);
        lft_out_t want;
        if (pending_bytes.size() == 0)
        begin
            log_mismatch("unexpected line byte", got.line_byte, 0);
            return;
        end
        want = pending_bytes.pop_front();
        if (got.line_byte !== want.line_byte)
            log_mismatch("line_byte", got.line_byte, want.line_byte);
        if (got.byte_kind !== want.byte_kind)
            log_mismatch("byte_kind", got.byte_kind, want.byte_kind);
        if (got.run_last !== want.run_last)
            log_mismatch("run_last", got.run_last, want.run_last);
        bytes_checked++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    //------------------------------------------------------------------
    // Receiver: samples at the falling edge, checks and drives ready at
    // the rising edge. A requested hold-off is counted down here.
    //------------------------------------------------------------------
    initial
    begin
        lft_out_t got;
        logic     fire;
        int       stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            fire = rst_n && result_valid && result_ready;
            got  = result;
            @(posedge clk);
            if (fire)
                check_line_byte(got);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
                holds_done++;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 99) < 25)
            begin
                result_ready <= 1'b0;
                stall_left = idle_len();
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge of the transfer
    // with valid still high, so the next call or a drain decides its level.
    //------------------------------------------------------------------
    task automatic send_item(input lft_in_t it);
        int   gap;
        logic acc;
        gap = tx_idle_on ? idle_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            acc = item_ready;
            if (!acc)
                input_stall_cycles++;
            @(posedge clk);
        end
        while (!acc);
        predict_line_bytes(it);
        items_sent++;
    endtask

    // Drop valid, let every owed byte arrive, then let the DUT go quiet.
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic lft_in_t make_item(input logic s, input logic e, input logic [5:0] id,
                                          input logic [7:0] d);
        lft_in_t it;
        it.start_frame = s;
        it.end_frame   = e;
        it.frame_id    = id;
        it.data_byte   = d;
        return it;
    endfunction

    function automatic lft_in_t rand_item(input logic s, input logic e);
        return make_item(s, e, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Data before any frame must produce nothing, end flag or not.
    task automatic test_data_outside_frame();
        send_item(make_item(1'b0, 1'b0, 6'h3F, 8'hFF));
        send_item(make_item(1'b0, 1'b1, 6'h00, 8'h00));
        wait_drain();
    endtask

    // Lowest and highest identifiers, data extremes, header with immediate checksum.
    task automatic test_header_extremes();
        send_item(make_item(1'b1, 1'b0, 6'h00, 8'hAA));   // data_byte ignored on start
        send_item(make_item(1'b0, 1'b0, 6'h3F, 8'h00));   // frame_id ignored on data
        send_item(make_item(1'b0, 1'b1, 6'h15, 8'hFF));
        send_item(make_item(1'b1, 1'b1, 6'h3F, 8'hFF));   // empty frame: inverted PID
        wait_drain();
    endtask

    // A start inside an open frame abandons it without checksum.
    task automatic test_restart_open_frame();
        send_item(make_item(1'b1, 1'b0, 6'h15, 8'h00));
        send_item(make_item(1'b0, 1'b0, 6'h00, 8'h80));
        send_item(make_item(1'b1, 1'b0, 6'h2A, 8'h55));
        send_item(make_item(1'b0, 1'b1, 6'h00, 8'h7F));
        send_item(make_item(1'b0, 1'b1, 6'h11, 8'h42));   // frame now closed: ignored
        wait_drain();
    endtask

    // Repeated carries through the end-around fold.
    task automatic test_checksum_carry();
        send_item(make_item(1'b1, 1'b0, 6'h3C, 8'h00));
        send_item(make_item(1'b0, 1'b0, 6'h00, 8'hFF));
        send_item(make_item(1'b0, 1'b0, 6'h00, 8'hFF));
        send_item(make_item(1'b0, 1'b1, 6'h00, 8'h01));
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps going: the job queue fills
    // and item_ready must drop without losing anything.
    task automatic test_output_hold_off();
        tx_idle_on = 1'b0;
        hold_req   = 80;
        send_item(rand_item(1'b1, 1'b0));
        for (int k = 0; k < 8; k++)
            send_item(rand_item(1'b0, k == 7));
        wait_drain();
        tx_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some noise and broken frames.
    task automatic test_random_traffic();
        int r;
        int n_data;
        while (items_effective < ITEM_TARGET)
        begin
            r          = $urandom_range(0, 99);
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            if (r < 85)
            begin
                n_data = $urandom_range(0, 8);
                send_item(rand_item(1'b1, n_data == 0 && $urandom_range(0, 3) != 0));
                for (int k = 0; k < n_data; k++)
                    send_item(rand_item(1'b0, k == n_data - 1));
            end
            else if (r < 93)
            begin
                send_item(rand_item(1'b0, 1'($urandom_range(0, 1))));
            end
            else
            begin
                // Frame left open; the next start drops it.
                send_item(rand_item(1'b1, 1'b0));
                n_data = $urandom_range(1, 4);
                for (int k = 0; k < n_data; k++)
                    send_item(rand_item(1'b0, 1'b0));
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drain();
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        frm_open   = 1'b0;
        csum_acc   = 8'h00;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 0;
        err_count  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_data_outside_frame();
        test_header_extremes();
        test_restart_open_frame();
        test_checksum_carry();
        test_output_hold_off();
        test_random_traffic();

        if (pending_bytes.size() != 0)
            log_mismatch("bytes never received", pending_bytes.size(), 0);

        $display("Run covered %0d items (%0d producing bytes), %0d line bytes checked.",
                 items_sent, items_effective, bytes_checked);
        $display("Frames closed %0d, dropped %0d; hold-offs %0d, input stall cycles %0d.",
                 frames_closed, frames_dropped, holds_done, input_stall_cycles);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> lin_frame_transmitter_top.f
sv/lft_pkg.sv
sv/lft_front.sv
sv/lft_queue.sv
sv/lft_back.sv
sv/lft_top.sv
tb/sv/lin_frame_transmitter_top_tb.sv
